// File: design/lock_order_cycle_checker_macros.svh
`ifndef LOCK_ORDER_CYCLE_CHECKER_MACROS_SVH
`define LOCK_ORDER_CYCLE_CHECKER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define LOC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LOC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/loc_pkg.sv
`default_nettype none
package loc_pkg;

   localparam int KEY_W    = 64;
   localparam int STATUS_W = 3;
   localparam int IDX_W    = 5;

   localparam logic MODE_ACQUIRE = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DEADLOCK     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REL_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REL_MISMATCH = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_STACK_FULL   = 3'd5;

   typedef struct packed {
      logic             mode;
      logic [KEY_W-1:0] lock_key;
   } loc_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    lock_index;
      logic                edge_added;
      logic [IDX_W-1:0]    cycle_from;
      logic [IDX_W-1:0]    cycle_to;
   } loc_result_type;

endpackage
`default_nettype wire

// File: design/loc_front.sv
`default_nettype none
module loc_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  loc_pkg::loc_item_type in_item,
   output logic                 q_valid,
   input  wire                  q_pop,
   output loc_pkg::loc_item_type q_item
);
   import loc_pkg::*;

   loc_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;
   logic         push;
   logic         pop;

   assign in_ready = (fill_ff != 2'd2);
   assign q_valid  = (fill_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

// File: design/loc_back.sv
`default_nettype none
module loc_back #(
   parameter int MAX_LOCKS   = 32,
   parameter int STACK_DEPTH = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    q_valid,
   output logic                   q_pop,
   input  loc_pkg::loc_item_type  q_item,
   output logic                   out_valid,
   input  wire                    out_ready,
   output loc_pkg::loc_result_type out_result
);
   import loc_pkg::*;

   localparam int IW = $clog2(MAX_LOCKS);
   localparam int CW = $clog2(MAX_LOCKS + 1);
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int WW = IW + CW;

   typedef enum logic [3:0] {
      S_IDLE, S_LOOK, S_LCMP, S_DECIDE, S_EDGE, S_START, S_SCAN, S_POP, S_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic             mode_ff, mode_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic             found_ff, found_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [DW-1:0]    depth_ff, depth_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic             edge_ff, edge_in;
   logic [IW-1:0]    cfrom_ff, cfrom_in;
   logic [IW-1:0]    cto_ff, cto_in;
   logic [MAX_LOCKS-1:0] seen_ff, seen_in;
   logic [MAX_LOCKS-1:0] done_ff, done_in;
   logic [CW-1:0]    start_ff, start_in;
   logic [IW-1:0]    cur_ff, cur_in;
   logic [CW-1:0]    cur_t_ff, cur_t_in;
   logic [CW-1:0]    sp_ff, sp_in;
   logic             out_valid_ff, out_valid_in;
   loc_result_type   out_ff, out_in;
   logic [MAX_LOCKS-1:0] row_valid_ff, row_valid_in;

   logic [KEY_W-1:0]     key_mem [MAX_LOCKS];
   logic [IW-1:0]        held_mem [STACK_DEPTH];
   logic [MAX_LOCKS-1:0] edge_mem [MAX_LOCKS];
   logic [WW-1:0]        walk_mem [MAX_LOCKS];

   logic [KEY_W-1:0]     key_rd_ff;
   logic [IW-1:0]        top_ff;
   logic [MAX_LOCKS-1:0] row_rd_ff;
   logic                 row_ok_ff;
   logic [WW-1:0]        walk_rd_ff;

   logic                 key_we, key_re;
   logic [IW-1:0]        key_waddr, key_raddr;
   logic                 held_we, held_re;
   logic [SW-1:0]        held_waddr;
   logic [IW-1:0]        held_wdata;
   logic                 edge_we, edge_re;
   logic [IW-1:0]        edge_waddr, edge_raddr;
   logic [MAX_LOCKS-1:0] edge_wdata;
   logic                 walk_we, walk_re;
   logic [IW-1:0]        walk_waddr, walk_raddr;
   logic [WW-1:0]        walk_wdata;

   logic [MAX_LOCKS-1:0] row;
   logic [IW-1:0]        new_idx;
   logic [IW-1:0]        t_idx;
   logic [DW-1:0]        depth_m1;
   logic [CW-1:0]        sp_m1;

   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;
   assign row        = row_ok_ff ? row_rd_ff : '0;
   assign new_idx    = found_ff ? idx_ff : count_ff[IW-1:0];
   assign t_idx      = cur_t_ff[IW-1:0];
   assign depth_m1   = depth_ff - DW'(1);
   assign sp_m1      = sp_ff - CW'(1);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      depth_in     = depth_ff;
      status_in    = status_ff;
      edge_in      = edge_ff;
      cfrom_in     = cfrom_ff;
      cto_in       = cto_ff;
      seen_in      = seen_ff;
      done_in      = done_ff;
      start_in     = start_ff;
      cur_in       = cur_ff;
      cur_t_in     = cur_t_ff;
      sp_in        = sp_ff;
      out_in       = out_ff;
      row_valid_in = row_valid_ff;
      out_valid_in = out_valid_ff && !out_ready;
      key_we = 1'b0; key_re = 1'b0; key_waddr = '0; key_raddr = '0;
      held_we = 1'b0; held_re = 1'b0; held_waddr = '0; held_wdata = '0;
      edge_we = 1'b0; edge_re = 1'b0; edge_waddr = '0; edge_raddr = '0;
      edge_wdata = '0;
      walk_we = 1'b0; walk_re = 1'b0; walk_waddr = '0; walk_raddr = '0;
      walk_wdata = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               mode_in   = q_item.mode;
               key_in    = q_item.lock_key;
               scan_in   = '0;
               found_in  = 1'b0;
               idx_in    = '0;
               status_in = ST_OK;
               edge_in   = 1'b0;
               cfrom_in  = '0;
               cto_in    = '0;
               held_re   = (depth_ff != '0);
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            if (scan_ff == count_ff) begin
               state_in = S_DECIDE;
            end else begin
               key_re    = 1'b1;
               key_raddr = scan_ff[IW-1:0];
               state_in  = S_LCMP;
            end
         end
         S_LCMP: begin
            if (key_rd_ff == key_ff) begin
               found_in = 1'b1;
               idx_in   = scan_ff[IW-1:0];
               state_in = S_DECIDE;
            end else begin
               scan_in  = scan_ff + CW'(1);
               state_in = S_LOOK;
            end
         end
         S_DECIDE: begin
            state_in = S_OUT;
            if (mode_ff == MODE_ACQUIRE) begin
               if (!found_ff && count_ff == CW'(MAX_LOCKS)) begin
                  status_in = ST_TABLE_FULL;
               end else if (depth_ff == DW'(STACK_DEPTH)) begin
                  status_in = ST_STACK_FULL;
               end else begin
                  if (!found_ff) begin
                     key_we    = 1'b1;
                     key_waddr = count_ff[IW-1:0];
                     count_in  = count_ff + CW'(1);
                  end
                  idx_in     = new_idx;
                  held_we    = 1'b1;
                  held_waddr = depth_ff[SW-1:0];
                  held_wdata = new_idx;
                  depth_in   = depth_ff + DW'(1);
                  if (depth_ff != '0 && top_ff != new_idx) begin
                     edge_re    = 1'b1;
                     edge_raddr = top_ff;
                     state_in   = S_EDGE;
                  end
               end
            end else begin
               if (depth_ff == '0) begin
                  status_in = ST_REL_EMPTY;
               end else if (!found_ff || top_ff != idx_ff) begin
                  status_in = ST_REL_MISMATCH;
               end else begin
                  depth_in = depth_m1;
               end
            end
         end
         S_EDGE: begin
            if (row[idx_ff]) begin
               state_in = S_OUT;
            end else begin
               edge_we      = 1'b1;
               edge_waddr   = top_ff;
               edge_wdata   = row | (MAX_LOCKS'(1) << idx_ff);
               row_valid_in[top_ff] = 1'b1;
               edge_in      = 1'b1;
               seen_in      = '0;
               done_in      = '0;
               start_in     = '0;
               state_in     = S_START;
            end
         end
         S_START: begin
            if (start_ff == count_ff) begin
               state_in = S_OUT;
            end else if (seen_ff[start_ff[IW-1:0]]) begin
               start_in = start_ff + CW'(1);
            end else begin
               seen_in[start_ff[IW-1:0]] = 1'b1;
               cur_in     = start_ff[IW-1:0];
               cur_t_in   = '0;
               sp_in      = '0;
               edge_re    = 1'b1;
               edge_raddr = start_ff[IW-1:0];
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cur_t_ff == count_ff) begin
               done_in[cur_ff] = 1'b1;
               if (sp_ff == '0) begin
                  start_in = start_ff + CW'(1);
                  state_in = S_START;
               end else begin
                  sp_in      = sp_m1;
                  walk_re    = 1'b1;
                  walk_raddr = sp_m1[IW-1:0];
                  state_in   = S_POP;
               end
            end else if (row[t_idx] && !done_ff[t_idx]) begin
               if (!seen_ff[t_idx]) begin
                  seen_in[t_idx] = 1'b1;
                  walk_we    = 1'b1;
                  walk_waddr = sp_ff[IW-1:0];
                  walk_wdata = {cur_ff, cur_t_ff + CW'(1)};
                  sp_in      = sp_ff + CW'(1);
                  cur_in     = t_idx;
                  cur_t_in   = '0;
                  edge_re    = 1'b1;
                  edge_raddr = t_idx;
               end else begin
                  status_in = ST_DEADLOCK;
                  cfrom_in  = cur_ff;
                  cto_in    = t_idx;
                  state_in  = S_OUT;
               end
            end else begin
               cur_t_in = cur_t_ff + CW'(1);
            end
         end
         S_POP: begin
            cur_in     = walk_rd_ff[WW-1:CW];
            cur_t_in   = walk_rd_ff[CW-1:0];
            edge_re    = 1'b1;
            edge_raddr = walk_rd_ff[WW-1:CW];
            state_in   = S_SCAN;
         end
         S_OUT: begin
            if (!out_valid_ff || out_ready) begin
               out_in.status     = status_ff;
               out_in.lock_index = IDX_W'(idx_ff);
               out_in.edge_added = edge_ff;
               out_in.cycle_from = IDX_W'(cfrom_ff);
               out_in.cycle_to   = IDX_W'(cto_ff);
               out_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         depth_ff     <= '0;
         row_valid_ff <= '0;
         out_valid_ff <= 1'b0;
         seen_ff      <= '0;
         done_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         depth_ff     <= depth_in;
         row_valid_ff <= row_valid_in;
         out_valid_ff <= out_valid_in;
         seen_ff      <= seen_in;
         done_ff      <= done_in;
      end
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      scan_ff   <= scan_in;
      found_ff  <= found_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      edge_ff   <= edge_in;
      cfrom_ff  <= cfrom_in;
      cto_ff    <= cto_in;
      start_ff  <= start_in;
      cur_ff    <= cur_in;
      cur_t_ff  <= cur_t_in;
      sp_ff     <= sp_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_ff;
      end
      if (key_re) begin
         key_rd_ff <= key_mem[key_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (held_we) begin
         held_mem[held_waddr] <= held_wdata;
      end
      if (held_re) begin
         top_ff <= held_mem[depth_m1[SW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_waddr] <= edge_wdata;
      end
      if (edge_re) begin
         row_rd_ff <= edge_mem[edge_raddr];
         row_ok_ff <= row_valid_ff[edge_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (walk_we) begin
         walk_mem[walk_waddr] <= walk_wdata;
      end
      if (walk_re) begin
         walk_rd_ff <= walk_mem[walk_raddr];
      end
   end

endmodule
`default_nettype wire

// File: design/lock_order_cycle_checker.sv
`default_nettype none
// Lock-order checker: each request acquires or releases a lock named by a 64-bit key and gets
// exactly one response with a status, the lock's dense index, whether a new ordering edge was
// recorded, and the ends of a back edge on deadlock. Requests enter a two-entry queue; the
// engine behind it handles one request at a time. A lookup walks the key table, reading an
// entry in S_LOOK and comparing it in S_LCMP; a release or an acquire that adds no edge then
// goes on to the response. An acquire that adds a new edge runs a depth-first search over the
// edge matrix, reading one matrix row per node visit and testing one neighbour per cycle.
// All stores start empty after reset with no clearing pass.
module lock_order_cycle_checker #(
   parameter int MAX_LOCKS   = 32,
   parameter int STACK_DEPTH = 16
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire        req_mode,
   input  wire [63:0] req_lock_key,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [2:0] rsp_status,
   output logic [4:0] rsp_lock_index,
   output logic       rsp_edge_added,
   output logic [4:0] rsp_cycle_from,
   output logic [4:0] rsp_cycle_to
);
   import loc_pkg::*;

   loc_item_type   req_item;
   loc_item_type   q_item;
   logic           q_valid;
   logic           q_pop;
   loc_result_type result;

   assign req_item.mode     = req_mode;
   assign req_item.lock_key = req_lock_key;

   loc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_item  (req_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_item   (q_item)
   );

   loc_back #(
      .MAX_LOCKS   (MAX_LOCKS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   assign rsp_status     = result.status;
   assign rsp_lock_index = result.lock_index;
   assign rsp_edge_added = result.edge_added;
   assign rsp_cycle_from = result.cycle_from;
   assign rsp_cycle_to   = result.cycle_to;

endmodule
`default_nettype wire

// File: design/loc_checker.sv
`default_nettype none
`include "lock_order_cycle_checker_macros.svh"
module loc_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [2:0] rsp_status,
   input wire [4:0] rsp_lock_index,
   input wire       rsp_edge_added,
   input wire [4:0] rsp_cycle_from,
   input wire [4:0] rsp_cycle_to
);
   import loc_pkg::*;

   `LOC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   `LOC_ASSERT_NOW(a_deadlock_edge, rsp_valid && rsp_status == ST_DEADLOCK, rsp_edge_added, "deadlock without new edge")
   `LOC_ASSERT_NOW(a_cycle_ends, rsp_valid && rsp_status != ST_DEADLOCK, rsp_cycle_from == 5'd0 && rsp_cycle_to == 5'd0, "cycle ends set without deadlock")
   `LOC_ASSERT_NOW(a_table_full, rsp_valid && rsp_status == ST_TABLE_FULL, rsp_lock_index == 5'd0 && !rsp_edge_added, "table full changed state")
   `LOC_ASSERT_NOW(a_status_range, rsp_valid, rsp_status == ST_OK || rsp_status == ST_DEADLOCK || rsp_status == ST_REL_EMPTY || rsp_status == ST_REL_MISMATCH || rsp_status == ST_TABLE_FULL || rsp_status == ST_STACK_FULL, "bad status")

   logic unused_req;
   assign unused_req = req_valid & req_ready;

endmodule

bind lock_order_cycle_checker loc_checker u_loc_checker (.*);
`default_nettype wire

// File: tb/sv/lock_order_monitor.sv
`default_nettype none
module lock_order_monitor
   import loc_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   input  wire        req_ready,
   input  wire        req_mode,
   input  wire [63:0] req_lock_key,
   input  wire        rsp_valid,
   input  wire        rsp_ready,
   input  wire [2:0]  rsp_status,
   input  wire [4:0]  rsp_lock_index,
   input  wire        rsp_edge_added,
   input  wire [4:0]  rsp_cycle_from,
   input  wire [4:0]  rsp_cycle_to,
   output int         fail_count,
   output int         pending,
   output logic       stalled
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NLOCK = 32;
   localparam int NHELD = 16;
   localparam int IDLE_LIMIT = 12000;

   logic [63:0]    known_keys [NLOCK];
   int             key_total;
   bit             order_adj [NLOCK][NLOCK];
   int             held_idx [NHELD];
   int             held_total;
   loc_result_type expected_rsp [$];
   int             idle_cycles;

   function automatic bit find_lock(input logic [63:0] key, output int idx);
      idx = 0;
      for (int i = 0; i < key_total; i++) begin
         if (known_keys[i] == key) begin
            idx = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit find_back_edge(output int src, output int dst);
      int  order [NLOCK];
      bit  seen [NLOCK];
      bit  closed [NLOCK];
      int  cursor [NLOCK];
      int  walk [NLOCK];
      int  sp;
      int  counter;
      int  h;
      int  t;
      src = 0;
      dst = 0;
      counter = 0;
      for (int i = 0; i < NLOCK; i++) begin
         order[i] = 0;
         seen[i] = 0;
         closed[i] = 0;
         cursor[i] = 0;
      end
      for (int start = 0; start < key_total; start++) begin
         if (seen[start]) continue;
         sp = 0;
         seen[start] = 1;
         order[start] = counter++;
         walk[sp++] = start;
         while (sp > 0) begin
            h = walk[sp-1];
            t = cursor[h];
            while (t < key_total && !order_adj[h][t]) t++;
            if (t >= key_total) begin
               closed[h] = 1;
               sp--;
               continue;
            end
            cursor[h] = t + 1;
            if (!seen[t]) begin
               seen[t] = 1;
               order[t] = counter++;
               if (sp < NLOCK) walk[sp++] = t;
               continue;
            end
            if (order[h] < order[t]) continue;
            if (!closed[t]) begin
               src = h;
               dst = t;
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic loc_result_type predict_lock_step(input logic mode,
                                                        input logic [63:0] key);
      loc_result_type r;
      int  idx;
      int  top;
      int  src;
      int  dst;
      bit  known;
      r = '0;
      known = find_lock(key, idx);
      if (mode == MODE_ACQUIRE) begin
         if (!known && key_total >= NLOCK) begin
            r.status = ST_TABLE_FULL;
            idx = 0;
         end else if (held_total >= NHELD) begin
            r.status = ST_STACK_FULL;
            if (!known) idx = 0;
         end else begin
            r.status = ST_OK;
            if (!known) begin
               idx = key_total;
               known_keys[idx] = key;
               key_total++;
            end
            if (held_total > 0) begin
               top = held_idx[held_total-1];
               if (top != idx && !order_adj[top][idx]) begin
                  order_adj[top][idx] = 1;
                  r.edge_added = 1'b1;
                  if (find_back_edge(src, dst)) begin
                     r.status = ST_DEADLOCK;
                     r.cycle_from = src[4:0];
                     r.cycle_to = dst[4:0];
                  end
               end
            end
            held_idx[held_total++] = idx;
         end
      end else begin
         if (held_total == 0) begin
            r.status = ST_REL_EMPTY;
            if (!known) idx = 0;
         end else if (!known) begin
            r.status = ST_REL_MISMATCH;
            idx = 0;
         end else if (held_idx[held_total-1] != idx) begin
            r.status = ST_REL_MISMATCH;
         end else begin
            r.status = ST_OK;
            held_total--;
         end
      end
      r.lock_index = idx[4:0];
      return r;
   endfunction

   assign pending = expected_rsp.size();

   always @(posedge clock) begin
      loc_result_type got;
      loc_result_type want;
      if (reset) begin
         key_total <= 0;
         held_total <= 0;
         fail_count <= 0;
         idle_cycles <= 0;
         stalled <= 1'b0;
         expected_rsp.delete();
         for (int i = 0; i < NLOCK; i++)
            for (int j = 0; j < NLOCK; j++) order_adj[i][j] = 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) stalled <= 1'b1;
         end
         if (req_valid && req_ready)
            expected_rsp.push_back(predict_lock_step(req_mode, req_lock_key));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_lock_index, rsp_edge_added, rsp_cycle_from, rsp_cycle_to};
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (got.status !== want.status ||
                   got.lock_index !== want.lock_index ||
                   got.edge_added !== want.edge_added ||
                   got.cycle_from !== want.cycle_from ||
                   got.cycle_to !== want.cycle_to) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none
module tb_top;
   import loc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = MODE_ACQUIRE;
   logic [63:0] req_lock_key = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [4:0]  rsp_lock_index;
   logic        rsp_edge_added;
   logic [4:0]  rsp_cycle_from;
   logic [4:0]  rsp_cycle_to;
   int          fail_count;
   int          pending;
   logic        stalled;

   bit          quiet = 0;
   bit          hold_off_due = 0;
   logic [63:0] key_pool [36];
   logic [63:0] held_keys [$];

   always #4 clock = ~clock;

   lock_order_cycle_checker dut (.*);

   lock_order_monitor monitor (.*);

   task automatic send_beat(input logic mode, input logic [63:0] key);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_lock_key <= key;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if (mode == MODE_ACQUIRE && held_keys.size() < 16) held_keys.push_back(key);
      if (mode == MODE_RELEASE && held_keys.size() > 0 && held_keys[$] == key)
         void'(held_keys.pop_back());
   endtask

   always begin
      int n;
      @(posedge clock);
      if (!reset) begin
         if (hold_off_due) begin
            hold_off_due = 0;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (stalled) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int r;
      int span;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 36; i++) key_pool[i] = {$urandom, $urandom};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(MODE_RELEASE, key_pool[0]);
      send_beat(MODE_ACQUIRE, key_pool[0]);
      send_beat(MODE_ACQUIRE, key_pool[0]);
      send_beat(MODE_ACQUIRE, key_pool[1]);
      send_beat(MODE_RELEASE, key_pool[0]);
      send_beat(MODE_RELEASE, 64'h5555_aaaa_5555_aaaa);
      send_beat(MODE_RELEASE, key_pool[1]);
      send_beat(MODE_RELEASE, key_pool[0]);
      send_beat(MODE_RELEASE, key_pool[0]);
      send_beat(MODE_RELEASE, key_pool[1]);
      send_beat(MODE_ACQUIRE, key_pool[1]);
      send_beat(MODE_ACQUIRE, key_pool[0]);
      send_beat(MODE_RELEASE, key_pool[0]);
      send_beat(MODE_RELEASE, key_pool[1]);
      for (int i = 0; i < 17; i++) send_beat(MODE_ACQUIRE, key_pool[2]);
      for (int i = 0; i < 16; i++) send_beat(MODE_RELEASE, key_pool[2]);
      held_keys.delete();

      for (int i = 0; i < 580; i++) begin
         if (i == 120) hold_off_due = 1;
         if (i >= 500) quiet = 1;
         span = (i / 12 + 4 > 35) ? 35 : i / 12 + 4;
         r = $urandom_range(0, 99);
         if (r < 40 && held_keys.size() > 0)
            send_beat(MODE_RELEASE, held_keys[$]);
         else if (r < 92)
            send_beat(MODE_ACQUIRE, key_pool[$urandom_range(0, span)]);
         else if (r < 96)
            send_beat(MODE_RELEASE, key_pool[$urandom_range(0, span)]);
         else
            send_beat(1'($urandom_range(0, 1)), {$urandom, $urandom});
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
